// ----- hdl/spsf_pkg.sv -----
`default_nettype none
package spsf_pkg;

  localparam int MAX_ELEMENTS = 32;
  localparam int DATA_W = 32;
  localparam int SUM_W = DATA_W + 1;
  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  // Block bounds reach up to lo + 2 * width, which can exceed the element count.
  localparam int POS_W = CNT_W + 2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MSTART,
    S_MRUN,
    S_WSTART,
    S_WRUN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    data_t wdata;
    idx_t  raddr_a;
    idx_t  raddr_b;
  } mem_port_t;

  typedef struct packed {
    data_t a;
    data_t b;
  } mem_rd_t;

endpackage
`default_nettype wire

// ----- hdl/spsf_ram.sv -----
`default_nettype none
module spsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ----- hdl/spsf_ctrl.sv -----
`default_nettype none
module spsf_ctrl
  import spsf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire data_t     sample_value,
  input  wire logic      last_element,
  input  wire data_t     target_sum,
  output mem_port_t      mem0_port,
  output mem_port_t      mem1_port,
  input  wire mem_rd_t   mem0_rd,
  input  wire mem_rd_t   mem1_rd,
  output logic           out_valid,
  input  wire logic      out_ready,
  output data_t          low_value,
  output data_t          high_value,
  output logic           pair_found,
  output logic           last_result
);

  state_t state, state_next;
  cnt_t   count;
  pos_t   width;
  logic   src;
  pos_t   blk_lo, mid, blk_hi;
  pos_t   p, q, k;
  logic   pend_v;
  data_t  pend_lo, pend_hi;

  logic   accept, room, can_push, push;
  pos_t   n_ext, n_after;
  pos_t   mid_c, hi_c, lo_plus_w, blk_next;
  data_t  da, db;
  logic   take_a, blk_done, pass_done, sort_done;
  pos_t   p_n, q_n, k_n;
  logic signed [SUM_W-1:0] sum, target_ext;
  logic   eq, lt, walk_adv, walk_end;
  pos_t   wlo_n, whi_n;
  data_t  push_lo, push_hi;
  logic   push_found, push_last;

  // Decision logic shared by the sequencer and the datapath.
  always_comb begin
    accept     = in_valid && in_ready;
    room       = count < CNT_W'(MAX_ELEMENTS);
    can_push   = !out_valid || out_ready;
    n_ext      = POS_W'(count);
    n_after    = n_ext + POS_W'(room);

    da         = src ? mem1_rd.a : mem0_rd.a;
    db         = src ? mem1_rd.b : mem0_rd.b;

    lo_plus_w  = blk_lo + width;
    mid_c      = (lo_plus_w < n_ext) ? lo_plus_w : n_ext;
    hi_c       = ((blk_lo + (width << 1)) < n_ext) ? (blk_lo + (width << 1)) : n_ext;
    blk_next   = blk_lo + (width << 1);

    take_a     = (p < mid) && ((q >= blk_hi) || (da <= db));
    p_n        = p + POS_W'(take_a);
    q_n        = q + POS_W'(!take_a);
    k_n        = k + POS_W'(1);
    blk_done   = (k_n == blk_hi);
    pass_done  = blk_done && (blk_next >= n_ext);
    sort_done  = pass_done && ((width << 1) >= n_ext);

    sum        = $signed({da[DATA_W-1], da}) + $signed({db[DATA_W-1], db});
    target_ext = $signed({target_sum[DATA_W-1], target_sum});
    eq         = (sum == target_ext);
    lt         = (sum < target_ext);
    // A new match can only be parked once the previous one has left.
    walk_adv   = !(eq && pend_v && !can_push);
    wlo_n      = (!eq && lt) ? p + POS_W'(1) : p;
    whi_n      = (!eq && lt) ? q : q - POS_W'(1);
    walk_end   = walk_adv && (wlo_n >= whi_n);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (accept && last_element) begin
          state_next = (n_after >= POS_W'(2)) ? S_MSTART : S_FIN;
        end
      end
      S_MSTART: state_next = S_MRUN;
      S_MRUN: begin
        if (sort_done) begin
          state_next = S_WSTART;
        end else if (blk_done) begin
          state_next = S_MSTART;
        end
      end
      S_WSTART: state_next = S_WRUN;
      S_WRUN: begin
        if (walk_end) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (can_push) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    mem0_port  = '0;
    mem1_port  = '0;
    in_ready   = 1'b0;
    push       = 1'b0;
    push_lo    = '0;
    push_hi    = '0;
    push_found = 1'b0;
    push_last  = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ready        = 1'b1;
        mem0_port.we    = accept && room;
        mem0_port.waddr = IDX_W'(count);
        mem0_port.wdata = sample_value;
      end
      S_MSTART: begin
        mem0_port.raddr_a = IDX_W'(blk_lo);
        mem0_port.raddr_b = IDX_W'(mid_c);
      end
      S_MRUN: begin
        mem0_port.raddr_a = IDX_W'(p_n);
        mem0_port.raddr_b = IDX_W'(q_n);
        if (src) begin
          mem0_port.we    = 1'b1;
          mem0_port.waddr = IDX_W'(k);
          mem0_port.wdata = take_a ? da : db;
        end else begin
          mem1_port.we    = 1'b1;
          mem1_port.waddr = IDX_W'(k);
          mem1_port.wdata = take_a ? da : db;
        end
      end
      S_WSTART: begin
        mem0_port.raddr_a = '0;
        mem0_port.raddr_b = IDX_W'(n_ext - POS_W'(1));
      end
      S_WRUN: begin
        mem0_port.raddr_a = walk_adv ? IDX_W'(wlo_n) : IDX_W'(p);
        mem0_port.raddr_b = walk_adv ? IDX_W'(whi_n) : IDX_W'(q);
        push    = walk_adv && eq && pend_v;
        push_lo = pend_lo;
        push_hi = pend_hi;
        push_found = 1'b1;
      end
      S_FIN: begin
        push       = can_push;
        push_lo    = pend_v ? pend_lo : '0;
        push_hi    = pend_v ? pend_hi : '0;
        push_found = pend_v;
        push_last  = 1'b1;
      end
      default: begin
      end
    endcase
    mem1_port.raddr_a = mem0_port.raddr_a;
    mem1_port.raddr_b = mem0_port.raddr_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      width <= '0;
      src <= 1'b0;
      blk_lo <= '0;
      pend_v <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            count <= CNT_W'(n_after);
            if (last_element) begin
              width  <= POS_W'(1);
              src    <= 1'b0;
              blk_lo <= '0;
              pend_v <= 1'b0;
            end
          end
        end
        S_MRUN: begin
          if (pass_done) begin
            blk_lo <= '0;
            src    <= ~src;
            width  <= width << 1;
          end else if (blk_done) begin
            blk_lo <= blk_next;
          end
        end
        S_WSTART: pend_v <= 1'b0;
        S_WRUN: begin
          if (walk_adv && eq) begin
            pend_v <= 1'b1;
          end
        end
        S_FIN: begin
          if (can_push) begin
            count  <= '0;
            pend_v <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pointers and parked match carry no reset; the sequencer loads them before use.
  always_ff @(posedge clk) begin
    unique case (state)
      S_MSTART: begin
        p      <= blk_lo;
        q      <= mid_c;
        k      <= blk_lo;
        mid    <= mid_c;
        blk_hi <= hi_c;
      end
      S_MRUN: begin
        p <= p_n;
        q <= q_n;
        k <= k_n;
      end
      S_WSTART: begin
        p <= '0;
        q <= n_ext - POS_W'(1);
      end
      S_WRUN: begin
        if (walk_adv) begin
          p <= wlo_n;
          q <= whi_n;
          if (eq) begin
            pend_lo <= da;
            pend_hi <= db;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      low_value   <= push_lo;
      high_value  <= push_hi;
      pair_found  <= push_found;
      last_result <= push_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count above capacity");

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    state == S_WRUN |-> p < q)
    else $error("walk pointers crossed");

  a_merge_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MRUN |-> (k < blk_hi) && (p <= mid) && (q <= blk_hi))
    else $error("merge pointer outside its block");

  a_pair_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && pair_found |->
      ($signed({low_value[DATA_W-1], low_value}) + $signed({high_value[DATA_W-1], high_value}))
        == $signed({target_sum[DATA_W-1], target_sum}))
    else $error("reported pair does not match the target");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && pair_found |-> low_value <= high_value)
    else $error("reported pair out of order");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pair_found |-> low_value == '0 && high_value == '0 && last_result)
    else $error("malformed not-found result");

endmodule
`default_nettype wire

// ----- hdl/sorted_pair_sum_finder_core.sv -----
// Sorted pair-sum finder.
// Input channel (in_valid/in_ready): one signed sample_value per request;
// last_element closes the set. Up to MAX_ELEMENTS values are kept, extra ones
// are dropped. Values load at one request per cycle until the closing request.
// After the closing request the set is merge sorted between two
// one-port-write, two-port-read memories over ceil(log2 n) passes; a
// two-pointer walk then finds the matching pairs and registers the final
// result. Loading is blocked meanwhile.
// Output channel (out_valid/out_ready): each matching pair, smaller value
// first, in walk order; last_result marks the final one. A set with no match
// gives one result with pair_found low and both values zero.
// A stalled receiver holds the result register; the walk pauses on a further
// match until it drains. cfg_write_en/cfg_write_data set target_sum and
// should only change between sets. Reset (rst, synchronous) empties the set,
// clears target_sum and drops any pending result; no memory clear is needed.
`default_nettype none
module sorted_pair_sum_finder_core
  import spsf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_write_en,
  input  wire data_t cfg_write_data,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire data_t sample_value,
  input  wire logic  last_element,
  output logic       out_valid,
  input  wire logic  out_ready,
  output data_t      low_value,
  output data_t      high_value,
  output logic       pair_found,
  output logic       last_result
);

  data_t     target_sum;
  mem_port_t mem0_port, mem1_port;
  mem_rd_t   mem0_rd, mem1_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_write_en) begin
      target_sum <= cfg_write_data;
    end
  end

  spsf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_value_store (
    .clk     (clk),
    .we      (mem0_port.we),
    .waddr   (mem0_port.waddr),
    .wdata   (mem0_port.wdata),
    .raddr_a (mem0_port.raddr_a),
    .raddr_b (mem0_port.raddr_b),
    .rdata_a (mem0_rd.a),
    .rdata_b (mem0_rd.b)
  );

  spsf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_merge_scratch (
    .clk     (clk),
    .we      (mem1_port.we),
    .waddr   (mem1_port.waddr),
    .wdata   (mem1_port.wdata),
    .raddr_a (mem1_port.raddr_a),
    .raddr_b (mem1_port.raddr_b),
    .rdata_a (mem1_rd.a),
    .rdata_b (mem1_rd.b)
  );

  spsf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .last_element (last_element),
    .target_sum   (target_sum),
    .mem0_port    (mem0_port),
    .mem1_port    (mem1_port),
    .mem0_rd      (mem0_rd),
    .mem1_rd      (mem1_rd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .low_value    (low_value),
    .high_value   (high_value),
    .pair_found   (pair_found),
    .last_result  (last_result)
  );

endmodule
`default_nettype wire

// ----- verif/sorted_pair_sum_finder_core_tb.sv -----
`timescale 1ns / 100ps
module sorted_pair_sum_finder_core_tb
  import spsf_pkg::*;
;

  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  // Wait before a target change; covers sorting and walking a 32-entry set.
  localparam int SETTLE_CYCLES = 250;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 50;
  localparam int DIR_ROWS = 21;

  typedef struct packed {
    data_t lowv;
    data_t highv;
    logic  found;
    logic  is_last;
  } pair_result_t;

  typedef struct packed {
    data_t        v;
    logic         is_last;
    logic         typed;
    pair_result_t res;
  } dir_row_t;

  localparam pair_result_t NO_PAIR = '{0, 0, 1'b0, 1'b1};

  logic  clk;
  logic  rst = 1'b1;
  logic  cfg_write_en = 1'b0;
  data_t cfg_write_data = '0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  data_t sample_value = '0;
  logic  last_element = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b1;
  data_t low_value;
  data_t high_value;
  logic  pair_found;
  logic  last_result;

  sorted_pair_sum_finder_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_value   (sample_value),
    .last_element   (last_element),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .low_value      (low_value),
    .high_value     (high_value),
    .pair_found     (pair_found),
    .last_result    (last_result)
  );

  pair_result_t pair_q[$];
  data_t        open_set[$];
  data_t        target_now = '0;
  int           src_idle_pct = 0;
  int           sink_stall_pct = 0;
  int           errors = 0;
  int           samples_sent = 0;
  int           sets_closed = 0;
  int           pairs_seen = 0;
  int           misses_seen = 0;
  int           quiet_cycles = 0;

  // Directed sets, all under the reset target of zero.
  dir_row_t dir_table [0:DIR_ROWS-1] = '{
    '{32'sd5,    1'b1, 1'b1, NO_PAIR},
    '{DATA_MIN,  1'b0, 1'b0, '0},
    // The two minimum values sum to zero only if the sum wraps at 32 bits.
    '{DATA_MIN,  1'b1, 1'b1, NO_PAIR},
    '{32'sd3,    1'b0, 1'b0, '0},
    '{-32'sd3,   1'b1, 1'b1, '{-32'sd3, 32'sd3, 1'b1, 1'b1}},
    '{32'sd0,    1'b0, 1'b0, '0},
    '{32'sd0,    1'b1, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b1}},
    '{DATA_MAX,  1'b0, 1'b0, '0},
    '{32'sd1,    1'b0, 1'b0, '0},
    '{DATA_MIN,  1'b1, 1'b1, NO_PAIR},
    '{-32'sd5,   1'b0, 1'b0, '0},
    '{32'sd5,    1'b0, 1'b0, '0},
    '{-32'sd2,   1'b0, 1'b0, '0},
    '{32'sd2,    1'b0, 1'b0, '0},
    '{32'sd0,    1'b0, 1'b0, '0},
    '{32'sd0,    1'b0, 1'b0, '0},
    '{32'sd9,    1'b1, 1'b0, '0},
    '{32'sd1,    1'b0, 1'b0, '0},
    '{-32'sd1,   1'b0, 1'b0, '0},
    '{-32'sd1,   1'b0, 1'b0, '0},
    '{32'sd1,    1'b1, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stores one accepted value while the set has room; the closing request sorts the set and walks it.
  task automatic take_sample(input data_t v, input logic is_last, input logic typed,
                             input pair_result_t typed_res);
    data_t  srt[$];
    data_t  t;
    int     lo, hi, j, found;
    longint s;
    samples_sent++;
    if (open_set.size() < MAX_ELEMENTS) open_set.push_back(v);
    if (is_last) begin
      srt = open_set;
      for (int i = 1; i < srt.size(); i++) begin
        t = srt[i];
        j = i - 1;
        while (j >= 0 && srt[j] > t) begin
          srt[j+1] = srt[j];
          j--;
        end
        srt[j+1] = t;
      end
      found = 0;
      lo = 0;
      hi = srt.size() - 1;
      while (lo < hi) begin
        s = longint'(srt[lo]) + longint'(srt[hi]);
        if (s == longint'(target_now)) begin
          if (!typed) pair_q.push_back('{srt[lo], srt[hi], 1'b1, 1'b0});
          found++;
          hi--;
        end else if (s < longint'(target_now)) begin
          lo++;
        end else begin
          hi--;
        end
      end
      if (typed) pair_q.push_back(typed_res);
      else if (found == 0) pair_q.push_back(NO_PAIR);
      else pair_q[pair_q.size()-1].is_last = 1'b1;
      sets_closed++;
      open_set.delete();
    end
  endtask

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_sample(input data_t v, input logic is_last, input logic typed,
                             input pair_result_t typed_res);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample_value = v;
    last_element = is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    take_sample(v, is_last, typed, typed_res);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pair_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_target(input data_t t);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_write_data = t;
    @(negedge clk);
    cfg_write_en = 1'b0;
    target_now = t;
  endtask

  // Most values sit near half the target so that many pairs match.
  task automatic send_random_set(input int n);
    longint half;
    data_t  v;
    int     r;
    logic   flat;
    half = longint'(target_now) >>> 1;
    flat = ($urandom_range(9) == 0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (flat) v = data_t'(half);
      else if (r < 65) v = data_t'(half + longint'($urandom_range(9)) - 4);
      else if (r < 85) v = data_t'($urandom);
      else if (r < 90) v = '0;
      else if (r < 95) v = DATA_MIN;
      else v = DATA_MAX;
      send_sample(v, i == n - 1, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input data_t tgt,
                           input int n_items, input logic fill_first);
    int sent, sz, r, nsets;
    set_target(tgt);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    nsets = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (fill_first && nsets == 0) sz = MAX_ELEMENTS + 2;
      else if (r < 8) sz = $urandom_range(MAX_ELEMENTS + 4, MAX_ELEMENTS + 1);
      else if (r < 15) sz = 1;
      else sz = $urandom_range(12, 2);
      send_random_set(sz);
      sent += sz;
      nsets++;
      // After the first set, hold off the next one until the block has nothing left to report.
      if (nsets == 1) wait_drained();
    end
  endtask

  task automatic note_mismatch(input string field, input data_t want, input data_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(negedge clk) out_ready = ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk) begin
    pair_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pair_found) pairs_seen++;
      else misses_seen++;
      if (pair_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got %0d %0d %0b %0b", $time,
                   low_value, high_value, pair_found, last_result);
      end else begin
        want = pair_q.pop_front();
        if (low_value !== want.lowv) note_mismatch("low_value", want.lowv, low_value);
        if (high_value !== want.highv) note_mismatch("high_value", want.highv, high_value);
        if (pair_found !== want.found)
          note_mismatch("pair_found", data_t'(want.found), data_t'(pair_found));
        if (last_result !== want.is_last)
          note_mismatch("last_result", data_t'(want.is_last), data_t'(last_result));
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no request moved for %0d cycles, %0d results outstanding", $time,
             WATCHDOG_LIMIT, pair_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_sample(dir_table[i].v, dir_table[i].is_last, dir_table[i].typed, dir_table[i].res);

    run_phase(0, 0, DATA_MIN, 30, 1'b1);
    run_phase(88, 0, DATA_MAX, 20, 1'b0);
    run_phase(0, 88, data_t'($urandom), 20, 1'b0);
    run_phase(11, 11, data_t'(int'($urandom_range(40)) - 20), 20, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d values in %0d sets over five target settings.", samples_sent,
             sets_closed);
    $display("Got %0d matching pairs and %0d not-found results; %0d mismatches.",
             pairs_seen, misses_seen, errors);
    if (errors == 0 && pair_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (pair_q.size() != 0) $display("%0d expected results never arrived", pair_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/spsf_pkg.sv
hdl/spsf_ram.sv
hdl/spsf_ctrl.sv
hdl/sorted_pair_sum_finder_core.sv
verif/sorted_pair_sum_finder_core_tb.sv
